@@ rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is active
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("deframer assertion failed");

// condition that must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	`ASSERT_CLK(lbl, clk, rstn, !(cond))

`endif

@@ rtl/dfr_pkg.sv @@
// Package for the byte unstuffing deframer: sizes, codes, command type.
// No dependencies; imported by the front, queue, back and top deframer modules.
`default_nettype none

package dfr_pkg;

	localparam int BUFFER_DEPTH = 1024;
	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int LEN_W = 11;
	localparam int IDX_W = 10;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] REG_DELIM = 2'd0;
	localparam logic [1:0] REG_ESC = 2'd1;
	localparam logic [1:0] REG_DELIM_HELP = 2'd2;
	localparam logic [1:0] REG_ESC_HELP = 2'd3;

	localparam logic [7:0] RST_DELIM = 8'd68;
	localparam logic [7:0] RST_ESC = 8'd69;
	localparam logic [7:0] RST_DELIM_HELP = 8'd100;
	localparam logic [7:0] RST_ESC_HELP = 8'd101;

	typedef struct packed {
		logic done;
		logic [LEN_W-1:0] length;
		logic wr;
		logic rd;
		logic [ADDR_W-1:0] addr;
		logic [7:0] wdata;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/dfr_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module dfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dfr_front.sv @@
// Front end: accepts items, holds config and frame state, classifies each
// item into a store command. Depends on dfr_pkg.
`default_nettype none

module dfr_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic operation,
	input  wire logic [7:0] byte_in,
	input  wire logic [dfr_pkg::IDX_W-1:0] read_index,
	input  wire logic q_full,
	output logic q_push,
	output dfr_pkg::cmd_t q_cmd
);
	import dfr_pkg::*;

`include "assert_macros.svh"

	logic [7:0] delim_q, esc_q, delim_help_q, esc_help_q;
	logic [CNT_W-1:0] stored_count_q, cnt_base, cnt_n;
	logic escape_pending_q, frame_good_q, frame_starting_q;
	logic esc_n, good_n, start_n;
	logic wr_en;
	logic [7:0] wr_byte;
	logic accept;

	assign cfg_ready = 1'b1;
	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;
	assign q_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= RST_DELIM;
			esc_q <= RST_ESC;
			delim_help_q <= RST_DELIM_HELP;
			esc_help_q <= RST_ESC_HELP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DELIM: delim_q <= cfg_data;
				REG_ESC: esc_q <= cfg_data;
				REG_DELIM_HELP: delim_help_q <= cfg_data;
				REG_ESC_HELP: esc_help_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cnt_base = frame_starting_q ? '0 : stored_count_q;
		cnt_n = stored_count_q;
		esc_n = escape_pending_q;
		good_n = frame_good_q;
		start_n = frame_starting_q;
		wr_en = 1'b0;
		wr_byte = byte_in;
		q_cmd = '0;
		if (operation == OP_READ) begin
			q_cmd.rd = int'(read_index) < BUFFER_DEPTH;
			q_cmd.addr = ADDR_W'(read_index);
		end else begin
			start_n = 1'b0;
			cnt_n = cnt_base;
			if (byte_in == delim_q) begin
				q_cmd.done = frame_good_q && !escape_pending_q;
				esc_n = 1'b0;
				good_n = 1'b1;
				start_n = 1'b1;
			end else if (frame_good_q) begin
				if (cnt_base >= CNT_W'(BUFFER_DEPTH)) begin
					good_n = 1'b0;
				end else if (escape_pending_q) begin
					esc_n = 1'b0;
					if (byte_in == delim_help_q) begin
						wr_en = 1'b1;
						wr_byte = delim_q;
					end else if (byte_in == esc_help_q) begin
						wr_en = 1'b1;
						wr_byte = esc_q;
					end else begin
						good_n = 1'b0;
					end
				end else if (byte_in == esc_q) begin
					esc_n = 1'b1;
				end else begin
					wr_en = 1'b1;
				end
			end
			if (wr_en) begin
				q_cmd.wr = 1'b1;
				q_cmd.addr = ADDR_W'(cnt_base);
				q_cmd.wdata = wr_byte;
				cnt_n = cnt_base + 1'b1;
			end
		end
		q_cmd.length = LEN_W'(cnt_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			escape_pending_q <= 1'b0;
			frame_good_q <= 1'b1;
			frame_starting_q <= 1'b1;
		end else if (accept) begin
			stored_count_q <= cnt_n;
			escape_pending_q <= esc_n;
			frame_good_q <= good_n;
			frame_starting_q <= start_n;
		end
	end

	`ASSERT_CLK(a_count_bound, clk, arst_n, stored_count_q <= CNT_W'(BUFFER_DEPTH))
	`ASSERT_CLK(a_done_no_write, clk, arst_n, !(q_push && q_cmd.done && (q_cmd.wr || q_cmd.rd)))

endmodule

`default_nettype wire

@@ rtl/dfr_queue.sv @@
// Short command queue between front and back ends.
// Depends on dfr_pkg.
`default_nettype none

module dfr_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire dfr_pkg::cmd_t push_cmd,
	output logic full,
	input  wire logic pop,
	output logic empty,
	output dfr_pkg::cmd_t head
);
	import dfr_pkg::*;

`include "assert_macros.svh"

	cmd_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QDEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`ASSERT_NEVER(a_push_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty)

endmodule

`default_nettype wire

@@ rtl/dfr_back.sv @@
// Back end: runs store writes and reads in item order, holds the result
// register. Depends on dfr_pkg and dfr_ram.
`default_nettype none

module dfr_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire dfr_pkg::cmd_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic message_done,
	output logic [dfr_pkg::LEN_W-1:0] message_length,
	output logic [7:0] read_data
);
	import dfr_pkg::*;

`include "assert_macros.svh"

	logic valid_s1, done_s1, rd_s1;
	logic [LEN_W-1:0] length_s1;
	logic out_valid_q, done_q;
	logic [LEN_W-1:0] length_q;
	logic [7:0] rdata_q;
	logic [7:0] ram_rdata;
	logic move_s1;

	assign move_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign q_pop = !q_empty && (!valid_s1 || move_s1);

	dfr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk(clk),
		.en(q_pop && (q_head.wr || q_head.rd)),
		.we(q_head.wr),
		.addr(q_head.addr),
		.wdata(q_head.wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) valid_s1 <= 1'b1;
			else if (move_s1) valid_s1 <= 1'b0;
			if (move_s1) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			done_s1 <= q_head.done;
			rd_s1 <= q_head.rd;
			length_s1 <= q_head.length;
		end
		if (move_s1) begin
			done_q <= done_s1;
			length_q <= length_s1;
			rdata_q <= rd_s1 ? ram_rdata : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign message_done = done_q;
	assign message_length = length_q;
	assign read_data = rdata_q;

	`ASSERT_CLK(a_rdata_held, clk, arst_n, valid_s1 && !move_s1 |=> $stable(ram_rdata))
	`ASSERT_CLK(a_done_zero_data, clk, arst_n, out_valid_q && done_q |-> rdata_q == 8'd0)

endmodule

`default_nettype wire

@@ rtl/byte_unstuffing_deframer.sv @@
// Byte unstuffing deframer: an item passes the command queue, stage s1
// and the result register. Throughput one item per cycle while in_stall
// is low; in_stall rises only when the 4-entry command queue is full.
// The store is a single-port RAM, at most one write or read per item,
// in order. arst_n clears frame state, count and queue, and loads the
// register defaults; the message store is not cleared.
`default_nettype none

module byte_unstuffing_deframer (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic operation,
	input  wire logic [7:0] byte_in,
	input  wire logic [dfr_pkg::IDX_W-1:0] read_index,
	output logic out_valid,
	input  wire logic out_stall,
	output logic message_done,
	output logic [dfr_pkg::LEN_W-1:0] message_length,
	output logic [7:0] read_data
);
	import dfr_pkg::*;

	cmd_t push_cmd, head;
	logic push, pop, full, empty;

	dfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.byte_in(byte_in),
		.read_index(read_index),
		.q_full(full),
		.q_push(push),
		.q_cmd(push_cmd)
	);

	dfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	dfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(empty),
		.q_head(head),
		.q_pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.message_done(message_done),
		.message_length(message_length),
		.read_data(read_data)
	);

endmodule

`default_nettype wire

@@ test/tb_byte_unstuffing_deframer.sv @@
// Testbench for byte_unstuffing_deframer: directed table, then framed random traffic
// over several register settings and idle/stall phases, scored against a local model.
// Depends on dfr_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module tb_byte_unstuffing_deframer;
	import dfr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int RESULT_LATENCY = 2;
	localparam int PHASE_ITEMS = 40;
	localparam int NUM_PHASES = 8;
	localparam int NUM_ROWS = 23;

	typedef struct packed {
		logic done;
		logic [LEN_W-1:0] length;
		logic [7:0] rdata;
	} result_t;

	typedef struct packed {
		logic op;
		logic [7:0] b;
		logic [IDX_W-1:0] idx;
		logic typed;
		result_t want;
	} dir_row_t;

	typedef enum logic [2:0] {
		MODE_NONE, MODE_SRC, MODE_SINK, MODE_BOTH, MODE_HOLD
	} idle_mode_t;

	// op, byte, index, typed, {done, length, read_data}
	localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
		{OP_FEED, 8'h41, 10'h000, 1'b1, 1'b0, 11'd1, 8'h00},
		{OP_FEED, 8'h45, 10'h3FF, 1'b0, 20'h0},
		{OP_FEED, 8'h64, 10'h000, 1'b0, 20'h0},
		{OP_FEED, 8'h45, 10'h155, 1'b0, 20'h0},
		{OP_FEED, 8'h65, 10'h2AA, 1'b0, 20'h0},
		{OP_FEED, 8'h00, 10'h000, 1'b1, 1'b0, 11'd4, 8'h00},
		{OP_FEED, 8'hFF, 10'h3FF, 1'b1, 1'b0, 11'd5, 8'h00},
		{OP_FEED, 8'h44, 10'h000, 1'b1, 1'b1, 11'd5, 8'h00},
		{OP_READ, 8'hFF, 10'd0, 1'b1, 1'b0, 11'd5, 8'h41},
		{OP_READ, 8'h00, 10'd1, 1'b0, 20'h0},
		{OP_READ, 8'hFF, 10'd2, 1'b0, 20'h0},
		{OP_READ, 8'h00, 10'd3, 1'b1, 1'b0, 11'd5, 8'h00},
		{OP_READ, 8'hFF, 10'd4, 1'b1, 1'b0, 11'd5, 8'hFF},
		{OP_FEED, 8'h42, 10'h000, 1'b0, 20'h0},
		{OP_FEED, 8'h45, 10'h000, 1'b0, 20'h0},
		{OP_FEED, 8'h78, 10'h000, 1'b0, 20'h0},
		{OP_FEED, 8'h43, 10'h000, 1'b0, 20'h0},
		{OP_FEED, 8'h44, 10'h000, 1'b1, 1'b0, 11'd1, 8'h00},
		{OP_FEED, 8'h45, 10'h000, 1'b0, 20'h0},
		{OP_FEED, 8'h44, 10'h000, 1'b1, 1'b0, 11'd0, 8'h00},
		{OP_FEED, 8'h44, 10'h000, 1'b1, 1'b1, 11'd0, 8'h00},
		{OP_READ, 8'h00, 10'd0, 1'b0, 20'h0},
		{OP_READ, 8'hFF, 10'd4, 1'b1, 1'b0, 11'd0, 8'hFF}
	};

	// delimiter, escape, delimiter helper, escape helper
	localparam logic [31:0] REG_SETS [NUM_PHASES] = '{
		32'h44456465, 32'h00FF01FE, 32'hFF000000, 32'h7E7E5E5D,
		32'h00000000, 32'h7E7D5E5D, 32'h00000000, 32'h44456465
	};
	localparam idle_mode_t PHASE_MODE [NUM_PHASES] = '{
		MODE_NONE, MODE_SRC, MODE_SINK, MODE_BOTH,
		MODE_HOLD, MODE_SINK, MODE_SRC, MODE_NONE
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_DELIM;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_FEED;
	logic [7:0] byte_in = 8'h00;
	logic [IDX_W-1:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic message_done;
	logic [LEN_W-1:0] message_length;
	logic [7:0] read_data;

	byte_unstuffing_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.byte_in(byte_in),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.message_done(message_done),
		.message_length(message_length),
		.read_data(read_data)
	);

	always #2 clk = ~clk;

	// deframer model state
	logic [7:0] msg_mem [BUFFER_DEPTH];
	int rx_count = 0;
	int mem_filled = 0;
	bit esc_armed = 1'b0;
	bit frame_ok = 1'b1;
	bit frame_fresh = 1'b1;
	logic [7:0] delim_r = RST_DELIM;
	logic [7:0] esc_r = RST_ESC;
	logic [7:0] dhelp_r = RST_DELIM_HELP;
	logic [7:0] ehelp_r = RST_ESC_HELP;

	result_t pending_results [$];
	result_t want_r;
	int fail_count = 0;
	int item_count = 0;
	int cycle_count = 0;
	int src_pct = 0;
	int hold_count = 0;
	idle_mode_t phase_mode = MODE_NONE;

	task automatic keep_byte(input logic [7:0] v);
		if (rx_count < BUFFER_DEPTH) begin
			msg_mem[rx_count] = v;
			rx_count++;
			if (rx_count > mem_filled)
				mem_filled = rx_count;
		end
	endtask

	task automatic deframe_step(input logic op, input logic [7:0] b,
			input logic [IDX_W-1:0] idx, output result_t r);
		r = '0;
		if (op == OP_READ) begin
			r.rdata = msg_mem[idx];
		end else begin
			if (frame_fresh) begin
				rx_count = 0;
				frame_fresh = 1'b0;
			end
			if (b == delim_r) begin
				r.done = frame_ok && !esc_armed;
				esc_armed = 1'b0;
				frame_ok = 1'b1;
				frame_fresh = 1'b1;
			end else if (frame_ok) begin
				if (rx_count >= BUFFER_DEPTH) begin
					frame_ok = 1'b0;
				end else if (esc_armed) begin
					esc_armed = 1'b0;
					if (b == dhelp_r)
						keep_byte(delim_r);
					else if (b == ehelp_r)
						keep_byte(esc_r);
					else
						frame_ok = 1'b0;
				end else if (b == esc_r) begin
					esc_armed = 1'b1;
				end else begin
					keep_byte(b);
				end
			end
		end
		r.length = rx_count[LEN_W-1:0];
	endtask

	task automatic push_item(input logic op, input logic [7:0] b,
			input logic [IDX_W-1:0] idx, input logic typed, input result_t typed_r);
		result_t r;
		while ($urandom_range(99) < src_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		byte_in <= b;
		read_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_step(op, b, idx, r);
		pending_results.push_back(typed ? typed_r : r);
		item_count++;
	endtask

	task automatic feed(input logic [7:0] b);
		push_item(OP_FEED, b, IDX_W'($urandom_range(BUFFER_DEPTH - 1)), 1'b0, '0);
	endtask

	task automatic read_at(input int idx);
		push_item(OP_READ, 8'($urandom_range(255)), IDX_W'(idx), 1'b0, '0);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(15))
			0: return delim_r;
			1: return esc_r;
			2: return dhelp_r;
			3: return ehelp_r;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_DELIM: delim_r = val;
			REG_ESC: esc_r = val;
			REG_DELIM_HELP: dhelp_r = val;
			default: ehelp_r = val;
		endcase
	endtask

	task automatic apply_config(input logic [31:0] word);
		settle();
		write_reg(REG_DELIM, word[31:24]);
		write_reg(REG_ESC, word[23:16]);
		write_reg(REG_DELIM_HELP, word[15:8]);
		write_reg(REG_ESC_HELP, word[7:0]);
		cfg_valid <= 1'b0;
	endtask

	// one frame of stuffed bytes, with some reads mixed in; some frames are broken on purpose
	task automatic send_frame();
		int n;
		int kind;
		int k;
		logic [7:0] v;
		n = $urandom_range(12);
		kind = $urandom_range(99);
		for (k = 0; k < n; k++) begin
			if (mem_filled > 0 && $urandom_range(99) < 15)
				read_at($urandom_range(mem_filled - 1));
			if (kind < 8 && k == n / 2) begin
				feed(esc_r);
				feed(8'($urandom_range(255)));
			end
			if (kind >= 15 && kind < 22 && k == n / 2) begin
				repeat (3)
					feed(8'($urandom_range(255)));
			end
			v = pick_byte();
			if (v == delim_r) begin
				feed(esc_r);
				feed(dhelp_r);
			end else if (v == esc_r) begin
				feed(esc_r);
				feed(ehelp_r);
			end else begin
				feed(v);
			end
		end
		if (kind >= 8 && kind < 15)
			feed(esc_r);
		feed(delim_r);
	endtask

	// fill the store, then overrun it with an escape byte and read back four entries
	task automatic send_long_frame();
		logic [7:0] v;
		repeat (BUFFER_DEPTH - 1) begin
			do
				v = 8'($urandom_range(255));
			while (v == delim_r || v == esc_r);
			feed(v);
		end
		feed(esc_r);
		feed(ehelp_r);
		feed(esc_r);
		feed(8'h41);
		feed(delim_r);
		read_at(BUFFER_DEPTH - 1);
		read_at(BUFFER_DEPTH - 2);
		read_at(BUFFER_DEPTH / 2);
		read_at(0);
	endtask

	always @(posedge clk) begin
		if (phase_mode == MODE_HOLD && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			if (phase_mode != MODE_HOLD)
				hold_count <= 0;
			case (phase_mode)
				MODE_SINK: out_stall <= ($urandom_range(99) < 58);
				MODE_BOTH: out_stall <= ($urandom_range(99) < 6);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: done %0d len %0d data %0d",
					$time, message_done, message_length, read_data);
				fail_count++;
			end else begin
				want_r = pending_results.pop_front();
				if (message_done !== want_r.done) begin
					$display("%0t: message_done expected %0d, got %0d",
						$time, want_r.done, message_done);
					fail_count++;
				end
				if (message_length !== want_r.length) begin
					$display("%0t: message_length expected %0d, got %0d",
						$time, want_r.length, message_length);
					fail_count++;
				end
				if (read_data !== want_r.rdata) begin
					$display("%0t: read_data expected %0d, got %0d",
						$time, want_r.rdata, read_data);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int i;
		int p;
		int phase_start;
		logic [31:0] word;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_ROWS; i++)
			push_item(DIR_ROWS[i].op, DIR_ROWS[i].b, DIR_ROWS[i].idx,
				DIR_ROWS[i].typed, DIR_ROWS[i].want);

		for (p = 0; p < NUM_PHASES; p++) begin
			word = REG_SETS[p];
			if (word == 32'h0)
				word = $urandom;
			apply_config(word);
			phase_mode <= PHASE_MODE[p];
			case (PHASE_MODE[p])
				MODE_SRC: src_pct = 58;
				MODE_BOTH: src_pct = 6;
				default: src_pct = 0;
			endcase
			if (p == 0)
				send_long_frame();
			phase_start = item_count;
			while (item_count - phase_start < PHASE_ITEMS)
				send_frame();
		end

		settle();
		if (fail_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
